FILE: rtl/core/rsd_pkg.sv
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared types and constants of the retry storm detector: command and result
// codes, register indexes, reset values and the structs between the modules.
// ----------------------------------------------------------------------------
package rsd_pkg;

  localparam logic [31:0] CMD_FLAG_MASK    = 32'h0000_0180;
  localparam logic [31:0] CMD_WAIT         = 32'd0;
  localparam logic [31:0] CMD_WAIT_BITSET  = 32'd9;
  localparam logic [31:0] RESULT_TRY_AGAIN = 32'hFFFF_FFF5;
  localparam logic [31:0] STREAK_MAX       = 32'hFFFF_FFFF;

  localparam logic [15:0] RST_STREAK_THRESHOLD = 16'd16;
  localparam logic [31:0] RST_WINDOW_NS        = 32'd10_000_000;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OBSERVE_ENABLE   = 8'd0,
    REG_MITIGATE_ENABLE  = 8'd1,
    REG_STREAK_THRESHOLD = 8'd2,
    REG_WINDOW_NS        = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic        observe_enable;
    logic        mitigate_enable;
    logic [15:0] streak_threshold;
    logic [31:0] window_ns;
  } rsd_cfg_t;

  typedef struct packed {
    logic [63:0]        call_address;
    logic [31:0]        op_word;
    logic [31:0]        expected_value;
    logic signed [31:0] call_result;
    logic [63:0]        now_ns;
  } rsd_item_t;

  typedef struct packed {
    logic [63:0] last_address;
    logic [31:0] last_op;
    logic [31:0] last_value;
    logic [31:0] repeat_streak;
    logic [63:0] first_repeat_time;
  } rsd_state_t;

  typedef struct packed {
    logic        yield_request;
    logic        storm_confirmed;
    logic        log_event;
    logic [31:0] streak_count;
    logic [63:0] elapsed_ns;
  } rsd_result_t;

endpackage

FILE: rtl/core/retry_storm_detector.sv
// ----------------------------------------------------------------------------
// retry_storm_detector
// Watches completed wait calls and flags a retry storm: the same wait
// failing with try-again back to back within a time window.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------
//  in       | in_valid / in_ready     | call_address, op_word, expected_value,
//           |                         | call_result, now_ns
//  out      | out_valid / out_ready   | yield_request, storm_confirmed,
//           |                         | log_event, streak_count, elapsed_ns
//  cfg      | cfg_wr_en (no wait)     | cfg_index, cfg_wdata
//
//  one item per cycle sustained while out_ready takes each result
//  the item is registered, then evaluated and the state updated as it moves
//  into the result register (one 64-bit compare, subtract and compare)
//  synchronous active-low reset clears config to defaults and state to zero
//  a stalled result holds the input register, which then drops in_ready
// ----------------------------------------------------------------------------
module retry_storm_detector #(
  parameter int unsigned LOG_REPEAT_PERIOD = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,

  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [63:0]                      in_call_address,
  input  logic [31:0]                      in_op_word,
  input  logic [31:0]                      in_expected_value,
  input  logic signed [31:0]               in_call_result,
  input  logic [63:0]                      in_now_ns,

  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_yield_request,
  output logic                             out_storm_confirmed,
  output logic                             out_log_event,
  output logic [31:0]                      out_streak_count,
  output logic [63:0]                      out_elapsed_ns,

  input  logic                             cfg_wr_en,
  input  logic [rsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rsd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import rsd_pkg::*;

  localparam int unsigned PHASE_W = $clog2(LOG_REPEAT_PERIOD);

  rsd_cfg_t           cfg_r;
  rsd_item_t          item_r;
  logic               item_valid_r;
  rsd_state_t         st_r;
  rsd_state_t         st_nxt;
  logic [PHASE_W-1:0] phase_r;
  logic [PHASE_W-1:0] phase_nxt;
  rsd_result_t        res_nxt;
  rsd_result_t        res_r;
  logic               out_valid_r;
  logic               out_load;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.observe_enable   <= 1'b0;
      cfg_r.mitigate_enable  <= 1'b0;
      cfg_r.streak_threshold <= RST_STREAK_THRESHOLD;
      cfg_r.window_ns        <= RST_WINDOW_NS;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_OBSERVE_ENABLE:   cfg_r.observe_enable   <= cfg_wdata[0];
        REG_MITIGATE_ENABLE:  cfg_r.mitigate_enable  <= cfg_wdata[0];
        REG_STREAK_THRESHOLD: cfg_r.streak_threshold <= cfg_wdata[15:0];
        REG_WINDOW_NS:        cfg_r.window_ns        <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  assign out_load = item_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !item_valid_r || out_load;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.call_address   <= in_call_address;
      item_r.op_word        <= in_op_word;
      item_r.expected_value <= in_expected_value;
      item_r.call_result    <= in_call_result;
      item_r.now_ns         <= in_now_ns;
    end
  end

  rsd_eval #(
    .LOG_REPEAT_PERIOD(LOG_REPEAT_PERIOD)
  ) u_eval (
    .cfg       (cfg_r),
    .item      (item_r),
    .st        (st_r),
    .phase     (phase_r),
    .st_nxt    (st_nxt),
    .phase_nxt (phase_nxt),
    .res       (res_nxt)
  );

  // detector state, updated as the item moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= '0;
      phase_r <= '0;
    end else if (out_load) begin
      st_r    <= st_nxt;
      phase_r <= phase_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_yield_request   = res_r.yield_request;
  assign out_storm_confirmed = res_r.storm_confirmed;
  assign out_log_event       = res_r.log_event;
  assign out_streak_count    = res_r.streak_count;
  assign out_elapsed_ns      = res_r.elapsed_ns;

`ifndef ASSERT_OFF
  a_yield_needs_storm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.yield_request |-> res_r.storm_confirmed)
    else $error("yield without confirmed storm");

  a_log_needs_storm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.log_event |-> res_r.storm_confirmed)
    else $error("log event without confirmed storm");

  a_phase_idle: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.repeat_streak == '0 |-> phase_r == '0)
    else $error("log phase nonzero with empty streak");

  a_storm_streak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.storm_confirmed |-> res_r.streak_count != '0)
    else $error("storm with zero streak");
`endif

endmodule

FILE: rtl/core/rsd_eval.sv
// ----------------------------------------------------------------------------
// rsd_eval
// Evaluates one wait return against the recorded call: next state, next
// log phase and the result flags.
// ----------------------------------------------------------------------------
module rsd_eval #(
  parameter int unsigned LOG_REPEAT_PERIOD = 256,
  localparam int unsigned PHASE_W = $clog2(LOG_REPEAT_PERIOD)
) (
  input  rsd_pkg::rsd_cfg_t    cfg,
  input  rsd_pkg::rsd_item_t   item,
  input  rsd_pkg::rsd_state_t  st,
  input  logic [PHASE_W-1:0]   phase,
  output rsd_pkg::rsd_state_t  st_nxt,
  output logic [PHASE_W-1:0]   phase_nxt,
  output rsd_pkg::rsd_result_t res
);
  import rsd_pkg::*;

  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(LOG_REPEAT_PERIOD - 1);
  localparam logic [PHASE_W-1:0] PHASE_ONE  = PHASE_W'(1);

  logic [31:0] cmd;
  logic        is_wait;
  logic        try_again;
  logic        call_hit;
  logic [63:0] elapsed;
  logic        storm;

  assign cmd       = item.op_word & ~CMD_FLAG_MASK;
  assign is_wait   = (cmd == CMD_WAIT) || (cmd == CMD_WAIT_BITSET);
  assign try_again = ($unsigned(item.call_result) == RESULT_TRY_AGAIN);
  assign call_hit  = (item.call_address == st.last_address) &&
                     (item.op_word == st.last_op) &&
                     (item.expected_value == st.last_value);
  assign elapsed   = item.now_ns - st.first_repeat_time;

  always_comb begin
    st_nxt    = st;
    phase_nxt = phase;
    storm     = 1'b0;
    res       = '0;
    if (cfg.observe_enable && is_wait) begin
      if (!try_again) begin
        if (st.repeat_streak != '0) begin
          st_nxt.repeat_streak = '0;
          st_nxt.last_address  = '0;
          phase_nxt            = '0;
        end
      end else if (!call_hit) begin
        st_nxt.last_address      = item.call_address;
        st_nxt.last_op           = item.op_word;
        st_nxt.last_value        = item.expected_value;
        st_nxt.repeat_streak     = 32'd1;
        st_nxt.first_repeat_time = item.now_ns;
        phase_nxt                = PHASE_ONE;
      end else begin
        if (st.repeat_streak != STREAK_MAX) begin
          st_nxt.repeat_streak = st.repeat_streak + 32'd1;
          phase_nxt            = (phase == PHASE_LAST) ? '0 : phase + PHASE_ONE;
        end
        storm = (st_nxt.repeat_streak >= {16'd0, cfg.streak_threshold}) &&
                (elapsed <= {32'd0, cfg.window_ns});
        res.elapsed_ns      = elapsed;
        res.storm_confirmed = storm;
        res.yield_request   = storm && cfg.mitigate_enable;
        res.log_event       = storm &&
                              ((st_nxt.repeat_streak == {16'd0, cfg.streak_threshold}) ||
                               (phase_nxt == '0));
      end
    end
    res.streak_count = st_nxt.repeat_streak;
  end

endmodule
